### rtl/core/mctp_pkg.sv
// ----------------------------------------------------------------------------
// mctp_pkg
// Shared types, action codes and time base constants of the timer pool.
// ----------------------------------------------------------------------------
`default_nettype none

package mctp_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int ID_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int MASK_W     = 16;
    localparam int CNT_W      = 16;
    localparam int BASE_W     = 3;
    localparam int MS_W       = 22;
    localparam int REM_W      = CNT_W + MS_W;

    typedef enum logic [3:0] {
        ACT_CREATE  = 4'd0,
        ACT_CHANGE  = 4'd1,
        ACT_FORCE   = 4'd2,
        ACT_START   = 4'd3,
        ACT_STOP    = 4'd4,
        ACT_DELETE  = 4'd5,
        ACT_RELOAD  = 4'd6,
        ACT_REMAIN  = 4'd7,
        ACT_QUERY   = 4'd8,
        ACT_TICK    = 4'd9
    } action_t;

    localparam logic [BASE_W-1:0] BASE_10MS  = 3'd0;
    localparam logic [BASE_W-1:0] BASE_100MS = 3'd1;
    localparam logic [BASE_W-1:0] BASE_1S    = 3'd2;
    localparam logic [BASE_W-1:0] BASE_1MIN  = 3'd3;
    localparam logic [BASE_W-1:0] BASE_1H    = 3'd4;

    // One channel's stored record.
    typedef struct packed {
        logic              single_shot;
        logic              notify_en;
        logic [BASE_W-1:0] base_sel;
        logic [CNT_W-1:0]  reload;
        logic [CNT_W-1:0]  count;
    } entry_t;

    function automatic logic [MS_W-1:0] base_ms(input logic [BASE_W-1:0] b);
        logic [MS_W-1:0] ms;
        unique case (b)
            BASE_10MS:  ms = MS_W'(10);
            BASE_100MS: ms = MS_W'(100);
            BASE_1S:    ms = MS_W'(1000);
            BASE_1MIN:  ms = MS_W'(60000);
            BASE_1H:    ms = MS_W'(3600000);
            default:    ms = '0;
        endcase
        return ms;
    endfunction

endpackage

`default_nettype wire

### rtl/core/mctp_chan_mem.sv
// ----------------------------------------------------------------------------
// mctp_chan_mem
// Channel record store: one write and one registered read port per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mctp_chan_mem (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          rd_en,
    input  wire [mctp_pkg::ID_W-1:0]     rd_addr,
    output mctp_pkg::entry_t             rd_data,
    input  wire                          wr_en,
    input  wire [mctp_pkg::ID_W-1:0]     wr_addr,
    input  wire mctp_pkg::entry_t        wr_data
);

    mctp_pkg::entry_t                   mem [mctp_pkg::NUM_TIMERS];
    logic [mctp_pkg::NUM_TIMERS-1:0]    written_reg;
    mctp_pkg::entry_t                   rd_entry_reg;
    logic                               rd_written_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_entry_reg <= mem[rd_addr];
        end
    end

    // Entries never written read as all zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_entry_reg : '0;

endmodule

`default_nettype wire

### rtl/core/multi_channel_timer_pool.sv
// ----------------------------------------------------------------------------
// multi_channel_timer_pool
// Pool of countdown timer channels on five time bases, with create, control,
// query and tick commands.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat is taken when start is high and busy is low. Exactly one
//   result beat follows, shown for one cycle with done high; the receiver
//   cannot stall it, so capture it in that cycle.
//   Create, start, stop, delete, query and rejected commands finish in the
//   cycle after acceptance and leave busy low: a new command may follow at
//   once.
//   Change period, force expire, reload and remaining read the channel
//   record from the registered record memory and finish in S_EXEC with
//   busy high; change and reload write the record back, force may.
//   A tick sweeps all NUM_TIMERS channels through the single memory read
//   port, one channel per cycle, reading channel c+1 while writing back
//   channel c, and holds busy high in S_SWEEP until the last channel.
//   Remaining time is count times the base length in ms, one multiply.
//   Reset frees and stops all channels and makes every record read as zero;
//   no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_timer_pool (
    input  wire                                     clk,
    input  wire                                     rst_n,
    input  wire                                     start,
    output logic                                    busy,
    input  wire  [3:0]                              action,
    input  wire  [3:0]                              timer_id,
    input  wire  [mctp_pkg::CNT_W-1:0]              period,
    input  wire  [mctp_pkg::BASE_W-1:0]             time_base,
    input  wire                                     one_shot,
    input  wire                                     reload_now,
    input  wire                                     notify,
    output logic                                    done,
    output logic                                    ok,
    output logic [3:0]                              given_id,
    output logic                                    is_running,
    output logic [mctp_pkg::REM_W-1:0]              remaining_ms,
    output logic [mctp_pkg::MASK_W-1:0]             expired_mask
);

    localparam int NT   = mctp_pkg::NUM_TIMERS;
    localparam int ID_W = mctp_pkg::ID_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP
    } state_t;

    state_t                         state_reg, state_next;

    // Channel ownership and run flags live in flops: create needs a
    // combinational lowest-idle search over all ownership flags.
    logic [NT-1:0]                  in_use_reg, in_use_next;
    logic [NT-1:0]                  running_reg, running_next;

    // Latched command fields.
    mctp_pkg::action_t              action_reg, action_next;
    logic [ID_W-1:0]                id_reg, id_next;
    logic [mctp_pkg::CNT_W-1:0]     period_reg, period_next;
    logic [mctp_pkg::BASE_W-1:0]    tb_reg, tb_next;
    logic                           reload_now_reg, reload_now_next;

    // Sweep position and expiry mask collected over a tick.
    logic [ID_W-1:0]                idx_reg, idx_next;
    logic [mctp_pkg::MASK_W-1:0]    acc_reg, acc_next;

    // Registered result beat.
    logic                           done_reg, done_next;
    logic                           ok_reg, ok_next;
    logic [3:0]                     given_reg, given_next;
    logic                           is_run_reg, is_run_next;
    logic [mctp_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [mctp_pkg::MASK_W-1:0]    mask_reg, mask_next;

    // Record memory port.
    logic                           rd_en;
    logic [ID_W-1:0]                rd_addr;
    mctp_pkg::entry_t               rd_data;
    logic                           wr_en;
    logic [ID_W-1:0]                wr_addr;
    mctp_pkg::entry_t               wr_data;

    // Lowest idle channel.
    logic                           free_found;
    logic [ID_W-1:0]                free_idx;

    logic                           id_ok;
    mctp_pkg::action_t              act_in;

    mctp_chan_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NT - 1; i >= 0; i--)
        begin
            if (!in_use_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = ID_W'(i);
            end
        end
    end

    assign id_ok  = (32'(timer_id) < NT);
    assign act_in = mctp_pkg::action_t'(action);
    assign busy   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        in_use_next     = in_use_reg;
        running_next    = running_reg;
        action_next     = action_reg;
        id_next         = id_reg;
        period_next     = period_reg;
        tb_next         = tb_reg;
        reload_now_next = reload_now_reg;
        idx_next        = idx_reg;
        acc_next        = acc_reg;

        done_next   = 1'b0;
        ok_next     = 1'b0;
        given_next  = '0;
        is_run_next = 1'b0;
        rem_next    = '0;
        mask_next   = '0;

        rd_en   = 1'b0;
        rd_addr = ID_W'(timer_id);
        wr_en   = 1'b0;
        wr_addr = id_reg;
        wr_data = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    action_next     = act_in;
                    id_next         = ID_W'(timer_id);
                    period_next     = period;
                    tb_next         = time_base;
                    reload_now_next = reload_now;

                    unique case (act_in)
                        mctp_pkg::ACT_CREATE:
                        begin
                            done_next = 1'b1;
                            if (free_found)
                            begin
                                in_use_next[free_idx]  = 1'b1;
                                running_next[free_idx] = 1'b0;
                                wr_en                  = 1'b1;
                                wr_addr                = free_idx;
                                wr_data.single_shot    = one_shot;
                                wr_data.notify_en      = notify;
                                wr_data.base_sel       = time_base;
                                wr_data.reload         = period;
                                wr_data.count          = period;
                                ok_next                = 1'b1;
                                given_next             = 4'(free_idx);
                            end
                        end
                        mctp_pkg::ACT_CHANGE, mctp_pkg::ACT_FORCE,
                        mctp_pkg::ACT_RELOAD, mctp_pkg::ACT_REMAIN:
                        begin
                            // Fetch the record, finish in S_EXEC.
                            if (id_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = S_EXEC;
                            end
                            else
                            begin
                                done_next = 1'b1;
                            end
                        end
                        mctp_pkg::ACT_START, mctp_pkg::ACT_STOP,
                        mctp_pkg::ACT_DELETE, mctp_pkg::ACT_QUERY:
                        begin
                            done_next = 1'b1;
                            if (id_ok)
                            begin
                                ok_next = 1'b1;
                                if (act_in == mctp_pkg::ACT_START)
                                begin
                                    running_next[ID_W'(timer_id)] = 1'b1;
                                end
                                if (act_in == mctp_pkg::ACT_STOP)
                                begin
                                    running_next[ID_W'(timer_id)] = 1'b0;
                                end
                                // Delete frees the channel but leaves it running.
                                if (act_in == mctp_pkg::ACT_DELETE)
                                begin
                                    in_use_next[ID_W'(timer_id)] = 1'b0;
                                end
                                if (act_in == mctp_pkg::ACT_QUERY)
                                begin
                                    is_run_next = running_reg[ID_W'(timer_id)];
                                end
                            end
                        end
                        mctp_pkg::ACT_TICK:
                        begin
                            // Start the sweep at channel 0.
                            rd_en      = 1'b1;
                            rd_addr    = '0;
                            idx_next   = '0;
                            acc_next   = '0;
                            state_next = S_SWEEP;
                        end
                        default:
                        begin
                            // Unknown command: reject, change nothing.
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            S_EXEC:
            begin
                done_next  = 1'b1;
                ok_next    = 1'b1;
                state_next = S_IDLE;
                unique case (action_reg)
                    mctp_pkg::ACT_CHANGE:
                    begin
                        wr_en          = 1'b1;
                        wr_data.reload = period_reg;
                        if (reload_now_reg)
                        begin
                            wr_data.count = period_reg;
                        end
                    end
                    mctp_pkg::ACT_FORCE:
                    begin
                        if (in_use_reg[id_reg] && running_reg[id_reg])
                        begin
                            if (rd_data.notify_en)
                            begin
                                mask_next = mctp_pkg::MASK_W'(1) << id_reg;
                            end
                            if (rd_data.single_shot)
                            begin
                                in_use_next[id_reg] = 1'b0;
                            end
                            else
                            begin
                                wr_en         = 1'b1;
                                wr_data.count = rd_data.reload;
                            end
                        end
                    end
                    mctp_pkg::ACT_RELOAD:
                    begin
                        wr_en         = 1'b1;
                        wr_data.count = rd_data.reload;
                    end
                    mctp_pkg::ACT_REMAIN:
                    begin
                        rem_next = mctp_pkg::REM_W'(rd_data.count)
                                 * mctp_pkg::REM_W'(mctp_pkg::base_ms(rd_data.base_sel));
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase
            end

            S_SWEEP:
            begin
                // rd_data holds channel idx_reg; write it back, fetch the next.
                wr_addr = idx_reg;
                if (in_use_reg[idx_reg] && running_reg[idx_reg]
                    && (rd_data.base_sel == tb_reg))
                begin
                    if (rd_data.count <= mctp_pkg::CNT_W'(1))
                    begin
                        if (rd_data.notify_en)
                        begin
                            acc_next = acc_reg | (mctp_pkg::MASK_W'(1) << idx_reg);
                        end
                        if (rd_data.single_shot)
                        begin
                            in_use_next[idx_reg] = 1'b0;
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_data.count = rd_data.reload;
                        end
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_data.count = rd_data.count - mctp_pkg::CNT_W'(1);
                    end
                end

                if (32'(idx_reg) == NT - 1)
                begin
                    done_next  = 1'b1;
                    ok_next    = 1'b1;
                    mask_next  = acc_next;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ID_W'(1);
                    rd_en    = 1'b1;
                    rd_addr  = idx_reg + ID_W'(1);
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            in_use_reg     <= '0;
            running_reg    <= '0;
            action_reg     <= mctp_pkg::ACT_CREATE;
            id_reg         <= '0;
            period_reg     <= '0;
            tb_reg         <= '0;
            reload_now_reg <= 1'b0;
            idx_reg        <= '0;
            acc_reg        <= '0;
            done_reg       <= 1'b0;
            ok_reg         <= 1'b0;
            given_reg      <= '0;
            is_run_reg     <= 1'b0;
            rem_reg        <= '0;
            mask_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            in_use_reg     <= in_use_next;
            running_reg    <= running_next;
            action_reg     <= action_next;
            id_reg         <= id_next;
            period_reg     <= period_next;
            tb_reg         <= tb_next;
            reload_now_reg <= reload_now_next;
            idx_reg        <= idx_next;
            acc_reg        <= acc_next;
            done_reg       <= done_next;
            ok_reg         <= ok_next;
            given_reg      <= given_next;
            is_run_reg     <= is_run_next;
            rem_reg        <= rem_next;
            mask_reg       <= mask_next;
        end
    end

    assign done         = done_reg;
    assign ok           = ok_reg;
    assign given_id     = given_reg;
    assign is_running   = is_run_reg;
    assign remaining_ms = rem_reg;
    assign expired_mask = mask_reg;

endmodule

`default_nettype wire
